// File: design/sparse_matrix_band_wavefront_metrics_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the band / wavefront metrics block
// Concurrent checks clocked on a rising edge and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_BAND_WAVEFRONT_METRICS_MACROS_SVH
`define SPARSE_MATRIX_BAND_WAVEFRONT_METRICS_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SMBW_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define SMBW_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/smbw_pkg.sv
// ---------------------------------------------------------------------------
// smbw_pkg
// Widths, word types and constants shared by the band / wavefront metrics
// block, its result queue and its stream interface users.
// ---------------------------------------------------------------------------
package smbw_pkg;

	localparam int MAX_NODES_DEF = 65536;

	localparam int IDX_W   = 16;
	localparam int DIST_W  = 16;
	localparam int FRONT_W = 17;
	localparam int PROF_W  = 32;
	localparam int SQ_W    = 49;
	localparam int PROD_W  = 2 * FRONT_W;

	localparam logic [FRONT_W-1:0] FRONT_CAP = FRONT_W'(65536);
	localparam logic [SQ_W-1:0]    SQ_CAP    = {SQ_W{1'b1}};

	// Result queue depth covers the issue-to-pop latency at full rate.
	localparam int FIFO_DEPTH = 8;
	localparam int CRED_W     = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [IDX_W-1:0] row_index;
		logic [IDX_W-1:0] column_index;
		logic             column_valid;
		logic             row_end;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   row_echo;
		logic [FRONT_W-1:0] row_wavefront;
		logic [FRONT_W-1:0] max_wavefront;
		logic [DIST_W-1:0]  bandwidth_so_far;
		logic [PROF_W-1:0]  profile_so_far;
		logic [SQ_W-1:0]    wavefront_square_sum;
	} result_t;

	// One bitmap access: a column mark or a row-end check.
	typedef struct packed {
		logic              is_row;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] span;
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

endpackage

// File: design/smbw_stream_if.sv
// ---------------------------------------------------------------------------
// smbw_stream_if
// Valid/ready stream channel carrying one payload word per handshake.
// ---------------------------------------------------------------------------
interface smbw_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: design/sparse_matrix_band_wavefront_metrics.sv
// ---------------------------------------------------------------------------
// sparse_matrix_band_wavefront_metrics
// Streams the nonzero pattern of a sparse symmetric matrix and reports, at
// each row end, the row wavefront with running bandwidth, profile, maximum
// wavefront and sum of squared wavefronts.
// ---------------------------------------------------------------------------
//
//  Channel   Dir  Word                 Moves when
//  --------  ---  -------------------  --------------------------------
//  items     in   smbw_pkg::item_t     items.valid && items.ready
//  results   out  smbw_pkg::result_t   results.valid && results.ready
//
//  One item per cycle while items.ready is high; a row-end item that also carries a
//  column stalls items.ready while its row check issues, since it needs two bitmap
//  updates on the single RAM write port. A result word is built in the pipeline
//  from its row-end item and then pushed into the result queue.
//  After reset the bitmap RAM is swept to zero, one entry per cycle, over all
//  MAX_NODES entries; items.ready stays low during the sweep.
//  Up to eight results may be queued; items.ready drops while eight are owed.
//
`include "sparse_matrix_band_wavefront_metrics_macros.svh"

module sparse_matrix_band_wavefront_metrics #(
	parameter int MAX_NODES = smbw_pkg::MAX_NODES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	smbw_stream_if.sink    items,
	smbw_stream_if.source  results
);
	localparam int AW    = $clog2(MAX_NODES);
	localparam int FW    = smbw_pkg::FRONT_W;
	localparam int DW    = smbw_pkg::DIST_W;
	localparam int IW    = smbw_pkg::IDX_W;
	localparam int PRW   = smbw_pkg::PROF_W;
	localparam int SQW   = smbw_pkg::SQ_W;
	localparam int PDW   = smbw_pkg::PROD_W;
	localparam int CRW   = smbw_pkg::CRED_W;
	localparam int SUM_W = SQW + 1;

	smbw_pkg::state_t state_q;
	logic [AW-1:0]    clr_cnt_q;

	logic             accept;
	logic             pop;
	logic [CRW-1:0]   credit_q;
	logic             hold_vld_q;
	logic [IW-1:0]    hold_row_q;

	// issue stage
	logic             iss_vld;
	smbw_pkg::op_t    iss_op;
	logic [31:0]      iss_wide;
	logic [AW-1:0]    iss_addr;
	logic             iss_in;

	// stage 1: bitmap data back, read-modify-write
	logic             op_vld_s1;
	smbw_pkg::op_t    op_s1;
	logic [AW-1:0]    addr_s1;
	logic             in_s1;
	logic             fwd_vld_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [0:0]       ram_rdata;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [0:0]       ram_wdata;
	logic             hit;
	logic [FW:0]      act_inc;
	logic [FW-1:0]    act_sat;
	logic [FW-1:0]    front_s1;
	logic [DW-1:0]    dist_max;
	logic [FW-1:0]    active_q;
	logic [DW-1:0]    rmax_q;

	// stage 2: running maxima, profile, square
	logic             row_vld_s2;
	logic [IW-1:0]    row_s2;
	logic [FW-1:0]    front_s2;
	logic [DW-1:0]    rmax_s2;
	logic [FW-1:0]    max_front_q;
	logic [DW-1:0]    max_dist_q;
	logic [PRW-1:0]   profile_q;
	logic [FW-1:0]    mf_new;
	logic [DW-1:0]    md_new;
	logic [PRW:0]     prof_sum;
	logic [PRW-1:0]   prof_new;

	// stage 3: square sum, push
	logic             row_vld_s3;
	smbw_pkg::result_t res_s3;
	logic [PDW-1:0]   prod_s3;
	logic [SQW-1:0]   square_q;
	logic [SUM_W-1:0] sq_sum;
	logic [SQW-1:0]   sq_new;
	smbw_pkg::result_t push_data;

	assign accept      = items.valid && items.ready;
	assign pop         = results.valid && results.ready;
	assign items.ready = (state_q == smbw_pkg::ST_RUN) && !hold_vld_q
		&& (credit_q < CRW'(smbw_pkg::FIFO_DEPTH));

	// Reset sweep, then run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= smbw_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				smbw_pkg::ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(MAX_NODES - 1)) begin
						state_q <= smbw_pkg::ST_RUN;
					end
				end
				smbw_pkg::ST_RUN: begin
					state_q <= smbw_pkg::ST_RUN;
				end
				default: begin
					state_q <= smbw_pkg::ST_CLEAR;
				end
			endcase
		end
	end

	// Column first, row check on the following cycle when one item holds both.
	always_comb begin
		iss_vld = 1'b0;
		iss_op  = '0;
		if (hold_vld_q) begin
			iss_vld       = 1'b1;
			iss_op.is_row = 1'b1;
			iss_op.idx    = hold_row_q;
		end else if (accept && items.data.column_valid) begin
			iss_vld     = 1'b1;
			iss_op.idx  = items.data.column_index;
			iss_op.span = (items.data.row_index > items.data.column_index)
				? items.data.row_index - items.data.column_index
				: items.data.column_index - items.data.row_index;
		end else if (accept && items.data.row_end) begin
			iss_vld       = 1'b1;
			iss_op.is_row = 1'b1;
			iss_op.idx    = items.data.row_index;
		end
	end

	assign iss_wide = 32'(iss_op.idx);
	assign iss_addr = iss_wide[AW-1:0];
	assign iss_in   = iss_wide < 32'(MAX_NODES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			credit_q   <= '0;
		end else begin
			if (hold_vld_q) begin
				hold_vld_q <= 1'b0;
			end else if (accept && items.data.column_valid && items.data.row_end) begin
				hold_vld_q <= 1'b1;
			end
			if ((accept && items.data.row_end) && !pop) begin
				credit_q <= credit_q + CRW'(1);
			end else if (pop && !(accept && items.data.row_end)) begin
				credit_q <= credit_q - CRW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_row_q <= items.data.row_index;
		end
	end

	assign ram_we    = (state_q == smbw_pkg::ST_CLEAR) || (op_vld_s1 && in_s1);
	assign ram_waddr = (state_q == smbw_pkg::ST_CLEAR) ? clr_cnt_q : addr_s1;
	assign ram_wdata = (state_q == smbw_pkg::ST_CLEAR) ? 1'b0 : 1'b1;

	smbw_ram #(
		.WIDTH (1),
		.DEPTH (MAX_NODES)
	) u_visited (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (iss_addr),
		.rdata (ram_rdata)
	);

	// Stage 1. The RAM read misses a mark written in the previous cycle: forward it.
	assign hit      = in_s1 && (ram_rdata[0] || (fwd_vld_q && (fwd_addr_q == addr_s1)));
	assign act_inc  = {1'b0, active_q} + (FW + 1)'(1);
	assign act_sat  = (act_inc > {1'b0, smbw_pkg::FRONT_CAP})
		? smbw_pkg::FRONT_CAP : act_inc[FW-1:0];
	assign front_s1 = hit ? active_q : act_sat;
	assign dist_max = (op_s1.span > rmax_q) ? op_s1.span : rmax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_vld_s1  <= 1'b0;
			fwd_vld_q  <= 1'b0;
			row_vld_s2 <= 1'b0;
			active_q   <= '0;
			rmax_q     <= '0;
		end else begin
			op_vld_s1  <= iss_vld;
			fwd_vld_q  <= op_vld_s1 && in_s1;
			row_vld_s2 <= op_vld_s1 && op_s1.is_row;
			if (op_vld_s1) begin
				if (!op_s1.is_row) begin
					rmax_q <= dist_max;
					if (in_s1 && !hit && (active_q < smbw_pkg::FRONT_CAP)) begin
						active_q <= active_q + FW'(1);
					end
				end else begin
					rmax_q <= '0;
					if (hit && (active_q != '0)) begin
						active_q <= active_q - FW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		op_s1      <= iss_op;
		addr_s1    <= iss_addr;
		in_s1      <= iss_in;
		fwd_addr_q <= addr_s1;
		row_s2     <= op_s1.idx;
		front_s2   <= front_s1;
		rmax_s2    <= rmax_q;
	end

	// Stage 2.
	assign mf_new   = (front_s2 > max_front_q) ? front_s2 : max_front_q;
	assign md_new   = (rmax_s2 > max_dist_q) ? rmax_s2 : max_dist_q;
	assign prof_sum = {1'b0, profile_q} + (PRW + 1)'(rmax_s2);
	assign prof_new = prof_sum[PRW] ? {PRW{1'b1}} : prof_sum[PRW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_s3  <= 1'b0;
			max_front_q <= '0;
			max_dist_q  <= '0;
			profile_q   <= '0;
			square_q    <= '0;
		end else begin
			row_vld_s3 <= row_vld_s2;
			if (row_vld_s2) begin
				max_front_q <= mf_new;
				max_dist_q  <= md_new;
				profile_q   <= prof_new;
			end
			if (row_vld_s3) begin
				square_q <= sq_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s3                 <= PDW'(front_s2) * PDW'(front_s2);
		res_s3.row_echo         <= row_s2;
		res_s3.row_wavefront    <= front_s2;
		res_s3.max_wavefront    <= mf_new;
		res_s3.bandwidth_so_far <= md_new;
		res_s3.profile_so_far   <= prof_new;
		res_s3.wavefront_square_sum <= '0;
	end

	// Stage 3: saturating square sum, then queue the word.
	assign sq_sum = {1'b0, square_q} + SUM_W'(prod_s3);
	assign sq_new = (sq_sum > {1'b0, smbw_pkg::SQ_CAP}) ? smbw_pkg::SQ_CAP : sq_sum[SQW-1:0];

	always_comb begin
		push_data                      = res_s3;
		push_data.wavefront_square_sum = sq_new;
	end

	smbw_fifo #(
		.DEPTH (smbw_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (row_vld_s3),
		.push_data (push_data),
		.results   (results)
	);

	`SMBW_ASSERT_IMPL(a_no_accept_in_clear, clk, arst_n,
		state_q == smbw_pkg::ST_CLEAR, !items.ready, "item accepted during bitmap sweep")
	`SMBW_ASSERT_IMPL(a_credit_bound, clk, arst_n,
		1'b1, credit_q <= CRW'(smbw_pkg::FIFO_DEPTH), "result credits exceed queue depth")
	`SMBW_ASSERT_NEXT(a_split_item, clk, arst_n,
		accept && items.data.column_valid && items.data.row_end,
		hold_vld_q && !items.ready, "row check of a split item not held")
	`SMBW_ASSERT_IMPL(a_result_owed, clk, arst_n,
		results.valid, credit_q != '0, "result offered with no credit outstanding")

endmodule

// File: design/smbw_ram.sv
// ---------------------------------------------------------------------------
// smbw_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data, old data returned on a read of the address being written.
// ---------------------------------------------------------------------------
module smbw_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = smbw_pkg::MAX_NODES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: design/smbw_fifo.sv
// ---------------------------------------------------------------------------
// smbw_fifo
// Small result queue that decouples the metrics pipeline from the result
// sink. Overflow is prevented upstream by a credit count.
// ---------------------------------------------------------------------------
module smbw_fifo #(
	parameter int DEPTH = smbw_pkg::FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  smbw_pkg::result_t   push_data,
	smbw_stream_if.source       results
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	smbw_pkg::result_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              pop;

	assign results.valid = (cnt_q != '0);
	assign results.data  = mem_q[rd_ptr_q];
	assign pop           = results.valid && results.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule

// File: tb/sparse_matrix_band_wavefront_metrics_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sparse_matrix_band_wavefront_metrics_tb
// Self-checking bench for the band / wavefront metrics block. It streams
// sparse row patterns (directed corners, banded rows with random content,
// noise, a back-pressure burst and a run of farthest-apart rows).
// It keeps its own copy of the visited bitmap and the running metrics, and
// compares every row result field by field.
// ---------------------------------------------------------------------------
module sparse_matrix_band_wavefront_metrics_tb;

	localparam int          CLK_HALF     = 6;
	localparam int          RESET_CYCLES = 5;
	localparam int          TAIL_CYCLES  = 24;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          BURST_ITEMS  = 40;
	localparam int          WIDE_ITEMS   = 40;
	localparam int unsigned FRONT_LIMIT  = 65536;
	localparam longint unsigned CYCLE_LIMIT = 64'd2_000_000;
	localparam longint unsigned PROFILE_MAX = 64'hFFFF_FFFF;
	localparam longint unsigned SQUARE_MAX  = (64'd1 << smbw_pkg::SQ_W) - 64'd1;

	logic clk = 1'b0;
	logic arst_n;

	smbw_stream_if #(.payload_t(smbw_pkg::item_t))   items_ch ();
	smbw_stream_if #(.payload_t(smbw_pkg::result_t)) results_ch ();

	sparse_matrix_band_wavefront_metrics uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_ch),
		.results(results_ch)
	);

	// Mirror of the block's state.
	bit              seen [smbw_pkg::MAX_NODES_DEF];
	int unsigned     open_cols    = 0;
	int unsigned     row_span     = 0;
	int unsigned     band         = 0;
	longint unsigned profile      = 0;
	int unsigned     peak_front   = 0;
	longint unsigned front_sq_sum = 0;

	smbw_pkg::result_t owed_rows [$];
	int unsigned     fail_count         = 0;
	int unsigned     sender_idle_pct    = 0;
	int unsigned     receiver_stall_pct = 0;
	int unsigned     hold_kick          = 0;
	int unsigned     hold_seen          = 0;
	int unsigned     hold_left          = 0;
	int              next_row           = 0;
	longint unsigned cycle_count        = 0;

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sparse_matrix_band_wavefront_metrics_tb NOT OK");
			$finish;
		end
	end

	// Result side: random stalls, plus a long hold-off whenever a test asks.
	always @(posedge clk) begin
		if (hold_kick != hold_seen) begin
			hold_seen        <= hold_kick;
			hold_left        <= HOLD_CYCLES;
			results_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left        <= hold_left - 1;
			results_ch.ready <= 1'b0;
		end else begin
			results_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : compare_rows
		smbw_pkg::result_t got;
		smbw_pkg::result_t want;
		if (results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
			got = results_ch.data;
			if (owed_rows.size() == 0) begin
				$error("result word for row %0d with none owed", got.row_echo);
				fail_count++;
			end else begin
				want = owed_rows.pop_front();
				check_field("row_echo", want.row_echo, got.row_echo);
				check_field("row_wavefront", want.row_wavefront, got.row_wavefront);
				check_field("max_wavefront", want.max_wavefront, got.max_wavefront);
				check_field("bandwidth_so_far", want.bandwidth_so_far, got.bandwidth_so_far);
				check_field("profile_so_far", want.profile_so_far, got.profile_so_far);
				check_field("wavefront_square_sum", want.wavefront_square_sum,
					got.wavefront_square_sum);
			end
		end
	end

	// Advance the mirrored metrics by one accepted word; queue the row result.
	task automatic step_metrics(input smbw_pkg::item_t it);
		int unsigned       gap;
		int unsigned       front;
		longint unsigned   sq;
		smbw_pkg::result_t r;
		if (it.column_valid) begin
			gap = (it.row_index > it.column_index) ? it.row_index - it.column_index
				: it.column_index - it.row_index;
			if (gap > row_span)
				row_span = gap;
			if (it.column_index < smbw_pkg::MAX_NODES_DEF && !seen[it.column_index]) begin
				seen[it.column_index] = 1'b1;
				if (open_cols < FRONT_LIMIT)
					open_cols++;
			end
		end
		if (it.row_end) begin
			if (it.row_index >= smbw_pkg::MAX_NODES_DEF || !seen[it.row_index]) begin
				if (it.row_index < smbw_pkg::MAX_NODES_DEF)
					seen[it.row_index] = 1'b1;
				front = open_cols + 1;
			end else begin
				front = open_cols;
				if (open_cols > 0)
					open_cols--;
			end
			if (front > FRONT_LIMIT)
				front = FRONT_LIMIT;
			if (front > peak_front)
				peak_front = front;
			if (row_span > band)
				band = row_span;
			profile += row_span;
			if (profile > PROFILE_MAX)
				profile = PROFILE_MAX;
			sq = longint'(front) * longint'(front);
			if (sq > SQUARE_MAX - front_sq_sum)
				front_sq_sum = SQUARE_MAX;
			else
				front_sq_sum += sq;
			row_span = 0;

			r.row_echo             = it.row_index;
			r.row_wavefront        = smbw_pkg::FRONT_W'(front);
			r.max_wavefront        = smbw_pkg::FRONT_W'(peak_front);
			r.bandwidth_so_far     = smbw_pkg::DIST_W'(band);
			r.profile_so_far       = smbw_pkg::PROF_W'(profile);
			r.wavefront_square_sum = smbw_pkg::SQ_W'(front_sq_sum);
			owed_rows.insert(owed_rows.size(), r);
		end
	endtask

	// Offer one word, idling first at the current rate; return once taken.
	task automatic send_item(input smbw_pkg::item_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			items_ch.valid <= 1'b0;
			@(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.data  <= it;
		do
			@(posedge clk);
		while (items_ch.ready !== 1'b1);
		step_metrics(it);
	endtask

	task automatic offer(input int row, input int col, input bit has_col, input bit last);
		smbw_pkg::item_t it;
		it.row_index    = smbw_pkg::IDX_W'(row);
		it.column_index = smbw_pkg::IDX_W'(col);
		it.column_valid = has_col;
		it.row_end      = last;
		send_item(it);
	endtask

	// Drop valid and hold until every owed result word has come back.
	task automatic wait_rows_drained();
		items_ch.valid <= 1'b0;
		while (owed_rows.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
		sender_idle_pct    = send_pct;
		receiver_stall_pct = stall_pct;
	endtask

	// Banded rows in increasing order with random content, plus some noise.
	task automatic send_pattern(input int n_items, input int spread);
		int cols;
		int k;
		int col;
		bit split_end;
		while (n_items > 0) begin
			if ($urandom_range(9) == 0) begin
				offer($urandom_range(65535), $urandom_range(65535), $urandom_range(1),
					$urandom_range(1));
				n_items--;
			end else begin
				cols = $urandom_range(5);
				if (cols == 0) begin
					offer(next_row, $urandom_range(65535), 1'b0, 1'b1);
					n_items--;
				end else begin
					split_end = ($urandom_range(3) == 0);
					for (k = 0; k < cols; k++) begin
						col = $urandom_range(1) ? next_row + $urandom_range(spread)
							: next_row - $urandom_range(spread);
						if (col < 0)
							col = 0;
						if (col > 65535)
							col = 65535;
						offer(next_row, col, 1'b1, (k == cols - 1) && !split_end);
						n_items--;
					end
					if (split_end) begin
						offer(next_row, $urandom_range(65535), 1'b0, 1'b1);
						n_items--;
					end
				end
				next_row += $urandom_range(1, 3);
				if (next_row > 65535)
					next_row = $urandom_range(255);
			end
		end
	endtask

	task automatic test_directed();
		set_idling(0, 0);
		offer(0, 0, 1'b1, 1'b0);
		offer(0, 65535, 1'b1, 1'b1);
		offer(65535, 0, 1'b1, 1'b1);
		// empty rows: first unvisited, then repeated with nothing active
		offer(1, 16'hFFFF, 1'b0, 1'b1);
		offer(1, 0, 1'b0, 1'b1);
		offer(2, 1, 1'b1, 1'b0);
		offer(2, 3, 1'b1, 1'b0);
		offer(2, 0, 1'b1, 1'b0);
		offer(2, 16'h5A5A, 1'b0, 1'b1);
		offer(2, 16'hA5A5, 1'b0, 1'b1);
		offer(16'h8000, 16'h7FFF, 1'b1, 1'b1);
		offer(16'h7FFF, 16'h8000, 1'b1, 1'b0);
		offer(16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
		// out of order row, then a marker that ends nothing
		offer(1, 2, 1'b1, 1'b1);
		offer(3, 0, 1'b0, 1'b0);
		offer(3, 4, 1'b1, 1'b1);
		wait_rows_drained();
		next_row = 4;
	endtask

	task automatic test_random_rows();
		set_idling(0, 0);
		send_pattern(480, 16);
		set_idling(64, 0);
		send_pattern(470, 300);
		wait_rows_drained();
		set_idling(0, 64);
		send_pattern(480, 65535);
		set_idling(19, 19);
		send_pattern(470, 40);
	endtask

	// Hold off the result side while rows keep coming: queue fills, input stalls.
	task automatic test_backpressure();
		int k;
		set_idling(0, 0);
		hold_kick++;
		for (k = 0; k < BURST_ITEMS; k++)
			offer($urandom_range(65535), $urandom_range(65535), $urandom_range(1), 1'b1);
		wait_rows_drained();
	endtask

	// Farthest-apart entries on every row end: widest distance, largest profile step.
	task automatic test_wide_rows();
		int k;
		set_idling(0, 0);
		for (k = 0; k < WIDE_ITEMS; k++)
			offer(0, 65535, 1'b1, 1'b1);
	endtask

	initial begin
		arst_n             = 1'b0;
		items_ch.valid     = 1'b0;
		items_ch.data      = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_rows();
		test_backpressure();
		test_wide_rows();

		set_idling(0, 0);
		wait_rows_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("sparse_matrix_band_wavefront_metrics_tb OK");
		else
			$display("sparse_matrix_band_wavefront_metrics_tb NOT OK");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/smbw_pkg.sv
design/smbw_stream_if.sv
design/smbw_ram.sv
design/smbw_fifo.sv
design/sparse_matrix_band_wavefront_metrics.sv
tb/sparse_matrix_band_wavefront_metrics_tb.sv
